/* src/bda_pkg.sv */
package bda_pkg;

   localparam int VALUE_BITS_DEF = 64;
   localparam int VALUE_WIDTH    = 64;
   localparam int CHAR_WIDTH     = 6;
   localparam int NIBBLE_WIDTH   = 4;

   localparam logic [CHAR_WIDTH-1:0]   ASCII_ZERO = 6'd48;
   localparam logic [NIBBLE_WIDTH-1:0] ADJ_LIMIT  = 4'd5;
   localparam logic [NIBBLE_WIDTH-1:0] ADJ_ADD    = 4'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic dabble;
      logic emit_shift;
   } ctrl_type;

endpackage

/* src/bda_dabble.sv */
module bda_dabble
   import bda_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int NUM_DIGITS = 20
) (
   input  logic                    clock,
   input  ctrl_type                ctrl,
   input  logic [VALUE_BITS-1:0]   value,
   output logic [NIBBLE_WIDTH-1:0] top_digit
);

   localparam int BCD_BITS = NIBBLE_WIDTH * NUM_DIGITS;

   logic [VALUE_BITS-1:0] bin_ff;
   logic [VALUE_BITS-1:0] bin_in;
   logic [BCD_BITS-1:0]   bcd_ff;
   logic [BCD_BITS-1:0]   bcd_in;
   logic [BCD_BITS-1:0]   bcd_adj;

   // Every digit of five or more gets three added before the shift.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*NIBBLE_WIDTH +: NIBBLE_WIDTH] >= ADJ_LIMIT) begin
            bcd_adj[i*NIBBLE_WIDTH +: NIBBLE_WIDTH] =
               bcd_ff[i*NIBBLE_WIDTH +: NIBBLE_WIDTH] + ADJ_ADD;
         end else begin
            bcd_adj[i*NIBBLE_WIDTH +: NIBBLE_WIDTH] =
               bcd_ff[i*NIBBLE_WIDTH +: NIBBLE_WIDTH];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = value;
         bcd_in = '0;
      end else if (ctrl.dabble) begin
         bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
      end else if (ctrl.emit_shift) begin
         bcd_in = {bcd_ff[BCD_BITS-NIBBLE_WIDTH-1:0], {NIBBLE_WIDTH{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_BITS-1 -: NIBBLE_WIDTH];

endmodule

/* src/bda_seq.sv */
module bda_seq
   import bda_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int NUM_DIGITS = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NIBBLE_WIDTH-1:0] top_digit,
   output logic                    busy,
   output ctrl_type                ctrl,
   output logic                    rsp_strobe,
   output logic                    rsp_last,
   output logic [NIBBLE_WIDTH-1:0] rsp_digit
);

   localparam int CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   state_type             state_ff;
   state_type             state_in;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [CNT_BITS-1:0]   cnt_in;
   logic                  started_ff;
   logic                  started_in;
   logic                  strobe_ff;
   logic                  strobe_in;
   logic                  last_ff;
   logic                  last_in;
   logic [NIBBLE_WIDTH-1:0] digit_ff;
   logic [NIBBLE_WIDTH-1:0] digit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         started_ff <= 1'b0;
         strobe_ff  <= 1'b0;
         last_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         started_ff <= started_in;
         strobe_ff  <= strobe_in;
         last_ff    <= last_in;
      end
      digit_ff <= digit_in;
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      started_in = started_ff;
      strobe_in  = 1'b0;
      last_in    = 1'b0;
      digit_in   = top_digit;
      ctrl       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.load  = 1'b1;
               cnt_in     = CNT_BITS'(VALUE_BITS - 1);
               started_in = 1'b0;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            ctrl.dabble = 1'b1;
            if (cnt_ff == '0) begin
               cnt_in   = CNT_BITS'(NUM_DIGITS - 1);
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            // Leading zeros are dropped; the final digit always goes out.
            ctrl.emit_shift = 1'b1;
            last_in         = (cnt_ff == '0);
            strobe_in       = started_ff || (top_digit != '0) || (cnt_ff == '0);
            started_in      = strobe_in;
            if (cnt_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_last   = last_ff;
   assign rsp_digit  = digit_ff;

endmodule

/* src/binary_to_decimal_ascii_top.sv */
// Converts an unsigned binary number into its decimal digits as ASCII codes.
// A transfer on the request side happens at a clock edge with start high and
// busy low; req_value is taken then, and only its low VALUE_BITS bits count.
// The number is converted by shift-add-3 steps, one bit per cycle, through a
// single shared BCD adjust-and-shift unit. The digits are then scanned from
// the top, one per cycle, as many as an unsigned VALUE_BITS-bit number can
// have decimal digits at most (20 for 64 bits); leading zeros are skipped
// without a strobe, and zero gives the single digit '0'.
// Each digit appears on rsp_digit_char for one cycle with rsp_strobe high,
// most significant first, and rsp_last marks the final digit of the run.
// Digits are registered before they are shown. Busy stays high through the
// conversion and the full digit scan, whatever the value. The final digit is
// shown in the cycle in which busy falls, when the next transfer can already
// be taken; no new request is taken while busy is high. The receiver has no
// way to hold results off, so a digit is transferred in the cycle it is shown.
// A synchronous reset returns the block to idle and drops any run in progress.
module binary_to_decimal_ascii_top
   import bda_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_strobe,
   output logic [CHAR_WIDTH-1:0]  rsp_digit_char,
   output logic                   rsp_last
);

   localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;

   ctrl_type                ctrl;
   logic [NIBBLE_WIDTH-1:0] top_digit;
   logic [NIBBLE_WIDTH-1:0] rsp_digit;

   bda_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_dabble (
      .clock     (clock),
      .ctrl      (ctrl),
      .value     (req_value[VALUE_BITS-1:0]),
      .top_digit (top_digit)
   );

   bda_seq #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .top_digit  (top_digit),
      .busy       (busy),
      .ctrl       (ctrl),
      .rsp_strobe (rsp_strobe),
      .rsp_last   (rsp_last),
      .rsp_digit  (rsp_digit)
   );

   assign rsp_digit_char = ASCII_ZERO | {{(CHAR_WIDTH-NIBBLE_WIDTH){1'b0}}, rsp_digit};

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after a request transfer");

   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside a digit run");

   a_end_of_run: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe && rsp_last)
      else $error("item finished without a final digit");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_digit_char <= 6'd57)
      else $error("digit out of decimal range");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import bda_pkg::*;

   localparam int VALUE_BITS = VALUE_BITS_DEF;
   localparam int MAX_DIGITS = 20;
   localparam int RANDOM_ITEMS = 400;
   localparam int CALM_ITEMS = 40;
   localparam int CYCLE_LIMIT = 500000;
   localparam logic [VALUE_WIDTH-1:0] DEC_BASE = 10;
   localparam logic [VALUE_WIDTH-1:0] VALUE_MASK =
      {VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - VALUE_BITS);

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] digit_char;
      logic                  last;
   } ascii_digit_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [VALUE_WIDTH-1:0] req_value = '0;
   logic                   rsp_strobe;
   logic [CHAR_WIDTH-1:0]  rsp_digit_char;
   logic                   rsp_last;

   logic [VALUE_WIDTH-1:0] pending_values[$];
   ascii_digit_type        expected_digits[$];
   logic                   req_taken = 1'b0;
   int                     gap_left = 0;
   int                     error_count = 0;
   int                     cycle_count = 0;

   binary_to_decimal_ascii_top #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last(rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void push_decimal_digits(input logic [VALUE_WIDTH-1:0] number);
      logic [VALUE_WIDTH-1:0]  rest;
      logic [NIBBLE_WIDTH-1:0] rev[MAX_DIGITS];
      int                      count;
      ascii_digit_type         d;
      rest = number & VALUE_MASK;
      count = 0;
      do begin
         rev[count] = NIBBLE_WIDTH'(rest % DEC_BASE);
         rest = rest / DEC_BASE;
         count++;
      end while (rest != 0 && count < MAX_DIGITS);
      for (int k = count - 1; k >= 0; k--) begin
         d.digit_char = CHAR_WIDTH'(rev[k]) + ASCII_ZERO;
         d.last = (k == 0);
         expected_digits.push_back(d);
      end
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] random_value();
      logic [VALUE_WIDTH-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: v = v >> $urandom_range(0, VALUE_WIDTH - 1);
         1: v = v >> $urandom_range(40, VALUE_WIDTH - 1);
         default: ;
      endcase
      return v;
   endfunction

   // The driver offers the next value once the previous transfer has happened.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_values.size() > 0) begin
            if (pending_values.size() > CALM_ITEMS && $urandom_range(0, 3) == 0) begin
               gap_left = $urandom_range(0, 10);
               start <= 1'b0;
            end else begin
               start <= 1'b1;
               req_value <= pending_values.pop_front();
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_taken <= !reset && start && !busy;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_digits.size() == 0) begin
               $display("%0t: unexpected digit, expected none, actual char %0d last %0d",
                        $time, rsp_digit_char, rsp_last);
               error_count++;
            end else begin
               ascii_digit_type want;
               want = expected_digits.pop_front();
               if (rsp_digit_char !== want.digit_char) begin
                  $display("%0t: digit_char mismatch, expected %0d, actual %0d",
                           $time, want.digit_char, rsp_digit_char);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch, expected %0d, actual %0d",
                           $time, want.last, rsp_last);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            push_decimal_digits(req_value);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      pending_values.push_back(64'd0);
      pending_values.push_back(64'd1);
      pending_values.push_back(64'd9);
      pending_values.push_back(64'd10);
      pending_values.push_back(64'd99);
      pending_values.push_back(64'd100);
      pending_values.push_back(64'd1000000000000000001);
      pending_values.push_back(64'd1234567890);
      pending_values.push_back(64'd9999999999999999999);
      pending_values.push_back(64'd10000000000000000000);
      pending_values.push_back(64'd18446744073709551615);
      pending_values.push_back(64'd18446744073709551614);
      pending_values.push_back(64'h8000_0000_0000_0000);
      pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
      pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
      pending_values.push_back(64'h5555_5555_5555_5555);
      pending_values.push_back(64'h0000_0001_0000_0000);
      pending_values.push_back(64'd4294967295);
      pending_values.push_back(64'd255);
      pending_values.push_back(64'd256);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pending_values.push_back(random_value());
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_values.size() > 0 || start) @(posedge clock);
      while (expected_digits.size() > 0) @(posedge clock);
      repeat (VALUE_BITS + MAX_DIGITS + 10) @(posedge clock);

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* binary_to_decimal_ascii_top.f */
src/bda_pkg.sv
src/bda_dabble.sv
src/bda_seq.sv
src/binary_to_decimal_ascii_top.sv
tb/sv/tb_top.sv
